// ----- hdl/bra_pkg.sv -----
// ----------------------------------------------------------------------------
// bra_pkg: shared types and constants of the bitmap run allocator
// Holds the request and response items, the run finder result, the
// controller states and the operation and status codes.
// ----------------------------------------------------------------------------
package bra_pkg;

	localparam int WORD_BITS = 64;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_MARK  = 1'b1;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FAIL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic        op;
		logic [12:0] count;
		logic [11:0] start_req;
		logic        set_value;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] bit_index;
	} rsp_item_t;

	typedef struct packed {
		logic                 found;
		logic [5:0]           pos;
		logic [WORD_BITS-1:0] mask;
	} fit_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC,
		S_MARK,
		S_FINISH
	} state_t;

endpackage

// ----- hdl/bra_mem.sv -----
// ----------------------------------------------------------------------------
// bra_mem: bitmap word store
// Single write port and single read port; read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module bra_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/bra_fit.sv -----
// ----------------------------------------------------------------------------
// bra_fit: first-fit run finder for one bitmap word
// Finds the lowest position where count free bits fit inside the word and
// builds the mask of that run.
// ----------------------------------------------------------------------------
module bra_fit (
	input  logic [63:0]        word,
	input  logic [6:0]         count,
	output bra_pkg::fit_t      fit
);
	import bra_pkg::*;

	logic [WORD_BITS-1:0] pw;
	logic [WORD_BITS-1:0] r;
	logic [5:0]           pos;
	logic [6:0]           run_end;

	// r holds the start positions of free runs as long as the count bits
	// seen so far; pw holds starts of free runs of length two to the i.
	always_comb begin
		pw = ~word;
		r  = '1;
		for (int i = 0; i < 7; i++) begin
			if (count[i]) begin
				r = r & (pw >> (count & ((7'd1 << i) - 7'd1)));
			end
			pw = pw & (pw >> (1 << i));
		end
	end

	always_comb begin
		pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (r[b]) begin
				pos = 6'(b);
			end
		end
	end

	assign run_end = {1'b0, pos} + count;

	always_comb begin
		fit.found = |r;
		fit.pos   = pos;
		for (int b = 0; b < WORD_BITS; b++) begin
			fit.mask[b] = (7'(b) >= {1'b0, pos}) && (7'(b) < run_end);
		end
	end

endmodule

// ----- hdl/bitmap_run_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_run_allocator: first-fit bitmap allocator with range marking
// Keeps a bitmap of 64-bit words in one memory and serves allocate and
// mark requests against it, one word per cycle.
// ----------------------------------------------------------------------------
// Usage:
// A request item enters on req_valid/req_stall, and one response item leaves
// on rsp_valid/rsp_stall for every request. cfg_valid/cfg_ready writes the
// number of words that allocation searches; cfg_ready is always high.
// After reset a clearing pass writes every word free, during which req_stall
// stays high. Requests are served one at a time.
// An allocate reads words from word 0 on until one holds its run or the
// searched words run out; a mark reads and rewrites each word of its range in
// turn. Allocates with a bad count or no word to search, empty marks and
// ranges beyond capacity skip the memory and go straight to the response.
// The next request can be accepted in the cycle after the response is loaded.
// The memory has one read and one write port and registered reads, so the
// scan moves one word per cycle.
// While the receiver stalls, the response waits in the output register; the
// next request is still accepted and its result is held until that register
// frees.
// ----------------------------------------------------------------------------
module bitmap_run_allocator #(
	parameter int WORDS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bra_pkg::req_item_t  req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bra_pkg::rsp_item_t  rsp_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [6:0]          cfg_data
);
	import bra_pkg::*;

	localparam int WW  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int WPW = WW + 1;
	localparam int LW  = (WPW > 7) ? WPW : 7;
	localparam logic [16:0] CAP_BITS = 17'(WORDS * WORD_BITS);

	state_t         state_q, state_d;
	logic [WPW-1:0] ptr_q, ptr_d;
	logic           rd_valid_s1, rd_valid_d;
	logic [WW-1:0]  rd_word_s1;
	logic [6:0]     words_in_use_q;
	logic           rsp_valid_q;
	rsp_item_t      rsp_item_q;

	logic [6:0]     count_q, count_d;
	logic           set_q, set_d;
	logic [WW-1:0]  sw_q, sw_d, ew_q, ew_d;
	logic [5:0]     lo_q, lo_d, hi_q, hi_d;
	logic [LW-1:0]  lim_q, lim_d;
	logic [1:0]     res_status_q, res_status_d;
	logic [11:0]    res_index_q, res_index_d;
	logic           rsp_load;

	logic           mem_we, mem_re;
	logic [WW-1:0]  mem_waddr, mem_raddr;
	logic [63:0]    mem_wdata, mem_rdata_s1, mark_mask;
	fit_t           fit;

	logic [13:0]    end_sum, end_m1;
	logic [15:0]    sw16, ew16, word16;
	logic [LW-1:0]  lim_now;
	logic           range_bad, count_bad, issue;

	bra_mem #(
		.DEPTH(WORDS),
		.AW   (WW),
		.DW   (WORD_BITS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata_s1)
	);

	bra_fit u_fit (
		.word (mem_rdata_s1),
		.count(count_q),
		.fit  (fit)
	);

	assign end_sum   = 14'(req_item.start_req) + req_item.count;
	assign end_m1    = end_sum - 14'd1;
	assign range_bad = 17'(end_sum) > CAP_BITS;
	assign count_bad = (req_item.count == '0) || (req_item.count > 13'd64);
	assign sw16      = 16'(req_item.start_req[11:6]);
	assign ew16      = 16'(end_m1[13:6]);
	assign lim_now   = (LW'(words_in_use_q) > LW'(WORDS)) ? LW'(WORDS) : LW'(words_in_use_q);
	assign issue     = LW'(ptr_q) < lim_q;
	assign word16    = 16'(rd_word_s1);

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			mark_mask[b] = ((rd_word_s1 != sw_q) || (6'(b) >= lo_q)) &&
			               ((rd_word_s1 != ew_q) || (6'(b) <= hi_q));
		end
	end

	always_comb begin
		state_d      = state_q;
		ptr_d        = ptr_q;
		rd_valid_d   = 1'b0;
		count_d      = count_q;
		set_d        = set_q;
		sw_d         = sw_q;
		ew_d         = ew_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		lim_d        = lim_q;
		res_status_d = res_status_q;
		res_index_d  = res_index_q;
		rsp_load     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = rd_word_s1;
		mem_wdata    = mem_rdata_s1;
		mem_re       = 1'b0;
		mem_raddr    = ptr_q[WW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[WW-1:0];
				mem_wdata = '0;
				if (ptr_q == WPW'(WORDS - 1)) begin
					ptr_d   = '0;
					state_d = S_IDLE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					res_index_d = '0;
					if (req_item.op == OP_ALLOC) begin
						if (count_bad || lim_now == '0) begin
							res_status_d = STATUS_FAIL;
							state_d      = S_FINISH;
						end else begin
							ptr_d   = '0;
							count_d = req_item.count[6:0];
							lim_d   = lim_now;
							state_d = S_ALLOC;
						end
					end else begin
						if (req_item.count == '0) begin
							res_status_d = STATUS_DONE;
							state_d      = S_FINISH;
						end else if (range_bad) begin
							res_status_d = STATUS_RANGE;
							state_d      = S_FINISH;
						end else begin
							ptr_d   = sw16[WPW-1:0];
							sw_d    = sw16[WW-1:0];
							ew_d    = ew16[WW-1:0];
							lo_d    = req_item.start_req[5:0];
							hi_d    = end_m1[5:0];
							set_d   = req_item.set_value;
							state_d = S_MARK;
						end
					end
				end
			end
			S_ALLOC: begin
				if (rd_valid_s1 && fit.found) begin
					mem_we       = 1'b1;
					mem_wdata    = mem_rdata_s1 | fit.mask;
					res_status_d = STATUS_DONE;
					res_index_d  = {word16[5:0], fit.pos};
					state_d      = S_FINISH;
				end else if (issue) begin
					mem_re     = 1'b1;
					ptr_d      = ptr_q + 1'b1;
					rd_valid_d = 1'b1;
				end else begin
					res_status_d = STATUS_FAIL;
					state_d      = S_FINISH;
				end
			end
			S_MARK: begin
				if (rd_valid_s1) begin
					mem_we    = 1'b1;
					mem_wdata = set_q ? (mem_rdata_s1 | mark_mask) :
					                    (mem_rdata_s1 & ~mark_mask);
				end
				if (rd_valid_s1 && rd_word_s1 == ew_q) begin
					res_status_d = STATUS_DONE;
					state_d      = S_FINISH;
				end else begin
					mem_re     = 1'b1;
					ptr_d      = ptr_q + 1'b1;
					rd_valid_d = 1'b1;
				end
			end
			S_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			ptr_q          <= '0;
			rd_valid_s1    <= 1'b0;
			rsp_valid_q    <= 1'b0;
			words_in_use_q <= 7'd64;
		end else begin
			state_q     <= state_d;
			ptr_q       <= ptr_d;
			rd_valid_s1 <= rd_valid_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				words_in_use_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_word_s1   <= ptr_q[WW-1:0];
		count_q      <= count_d;
		set_q        <= set_d;
		sw_q         <= sw_d;
		ew_q         <= ew_d;
		lo_q         <= lo_d;
		hi_q         <= hi_d;
		lim_q        <= lim_d;
		res_status_q <= res_status_d;
		res_index_q  <= res_index_d;
		if (rsp_load) begin
			rsp_item_q.status    <= res_status_q;
			rsp_item_q.bit_index <= res_index_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;
	assign cfg_ready = 1'b1;

	a_accept_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |-> !rd_valid_s1)
		else $error("request accepted while a word read is in flight");

	a_alloc_free_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC && mem_we) |-> ((mem_rdata_s1 & fit.mask) == '0))
		else $error("allocation claims a bit that is already used");

	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK && mem_we) |-> (rd_word_s1 >= sw_q && rd_word_s1 <= ew_q))
		else $error("mark writes a word outside its range");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FINISH))
		else $error("response raised outside the finish step");

endmodule
